>>> rtl/gopd_pkg.sv
// Package for the glyph outline point decoder: field codes, flag bits,
// error codes and the command, status and result structs. No dependencies.
package gopd_pkg;

    localparam int MAX_POINTS_DEF   = 64;
    localparam int MAX_CONTOURS_DEF = 16;

    localparam logic [15:0] SCALE_RESET = 16'd1024;

    // packed flag bits held per point
    localparam int FL_ON     = 0;
    localparam int FL_XSHORT = 1;
    localparam int FL_YSHORT = 2;
    localparam int FL_XSAME  = 3;
    localparam int FL_YSAME  = 4;

    // error codes
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_COMPOSITE = 2'd1;
    localparam logic [1:0] ERR_POINTS    = 2'd2;
    localparam logic [1:0] ERR_CONTOURS  = 2'd3;

    // delta source select
    localparam logic [1:0] DS_ZERO  = 2'd0;
    localparam logic [1:0] DS_SHORT = 2'd1;
    localparam logic [1:0] DS_WORD  = 2'd2;

    typedef struct packed {
        logic       glyph_init;
        logic       latch_byte;
        logic       bc_clr;
        logic       bc_inc;
        logic       bc_set1;
        logic       bc_dec;
        logic       bc_load;
        logic       set_ct;
        logic       set_bx;
        logic       set_by;
        logic       set_end;
        logic       set_pt;
        logic       pi_clr;
        logic       pi_inc;
        logic       flag_wr;
        logic       flag_rep;
        logic       latch_flag;
        logic       rep_load;
        logic       rep_dec;
        logic       x_wr;
        logic [1:0] x_sel;
        logic       y_add;
        logic [1:0] y_sel;
        logic       stage;
        logic       out_pt;
        logic       out_err;
        logic [1:0] err_code;
    } t_cmd;

    typedef struct packed {
        logic       bc_zero;
        logic       bc_one;
        logic       bc_odd;
        logic       bc_is3;
        logic       bc_is5;
        logic       bc_is9;
        logic       word_neg;
        logic       word_gt_mc;
        logic       word_zero;
        logic       word_ge_mp;
        logic       ends_last;
        logic       pi_done;
        logic       rep_zero;
        logic       byte_rep;
        logic [4:0] fl;
        logic       out_free;
    } t_sts;

    typedef struct packed {
        logic [15:0] x_offset;
        logic [15:0] y_offset;
        logic [23:0] x_scaled;
        logic [23:0] y_scaled;
        logic        on_curve;
        logic        contour_last;
        logic        glyph_last;
        logic [1:0]  error_code;
    } t_res;

endpackage

>>> rtl/gopd_ifs.sv
// Channel interfaces of the glyph outline point decoder: byte input,
// point output and configuration write. No dependencies.
interface gopd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       glyph_start;
    modport source (output valid, data_byte, glyph_start, input ready);
    modport sink   (input valid, data_byte, glyph_start, output ready);
endinterface

interface gopd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] x_offset;
    logic [15:0] y_offset;
    logic [23:0] x_scaled;
    logic [23:0] y_scaled;
    logic        on_curve;
    logic        contour_last;
    logic        glyph_last;
    logic [1:0]  error_code;
    modport source (output valid, x_offset, y_offset, x_scaled, y_scaled, on_curve,
                    contour_last, glyph_last, error_code, input ready);
    modport sink   (input valid, x_offset, y_offset, x_scaled, y_scaled, on_curve,
                    contour_last, glyph_last, error_code, output ready);
endinterface

interface gopd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/glyph_outline_point_decoder.sv
// Top level of the glyph outline point decoder: joins controller and datapath
// to the byte, point and configuration channels. Uses gopd_pkg, gopd_ifs, gopd_ctrl, gopd_dp.
//
//  channel  | dir | payload                                   | handshake
//  i_in     | in  | data_byte, glyph_start                    | valid/ready
//  o_out    | out | offsets, scaled Q16.8, on/contour/glyph/err| valid/ready
//  i_cfg    | in  | scale_factor (16 bit)                     | valid/ready, always ready
//
// Header, end and skip bytes and a flag byte with the repeat bit are taken in S_IN;
// any other flag byte passes S_FCHK, a repeat count S_REP and S_FCHK. The last
// byte of an X point passes S_XF and S_XC, that of a Y point S_E1, S_E2 (which
// waits for a free output), S_YF and S_YC, and each point with no delta bytes
// repeats that pass; the registered read of the flag and X memories sets these steps.
// Reset is synchronous, active low; the memories need no clearing.
// The output register frees the input side; a stalled output holds only the next point.
module glyph_outline_point_decoder #(
    parameter int MAX_POINTS   = gopd_pkg::MAX_POINTS_DEF,
    parameter int MAX_CONTOURS = gopd_pkg::MAX_CONTOURS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gopd_in_if.sink    i_in,
    gopd_out_if.source o_out,
    gopd_cfg_if.sink   i_cfg
);
    gopd_pkg::t_cmd cmd;
    gopd_pkg::t_sts sts;
    gopd_pkg::t_res res;

    assign i_cfg.ready = 1'b1;

    gopd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_glyph_start (i_in.glyph_start),
        .o_in_ready    (i_in.ready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    gopd_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_CONTOURS (MAX_CONTOURS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_byte      (i_in.data_byte),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_res       (res)
    );

    // drive the output word
    assign o_out.x_offset     = res.x_offset;
    assign o_out.y_offset     = res.y_offset;
    assign o_out.x_scaled     = res.x_scaled;
    assign o_out.y_scaled     = res.y_scaled;
    assign o_out.on_curve     = res.on_curve;
    assign o_out.contour_last = res.contour_last;
    assign o_out.glyph_last   = res.glyph_last;
    assign o_out.error_code   = res.error_code;

endmodule

>>> rtl/gopd_dp.sv
// Datapath of the glyph outline point decoder: counters, flag and X memories,
// accumulators, scaling multipliers and the output register. Uses gopd_pkg.
module gopd_dp #(
    parameter int MAX_POINTS   = gopd_pkg::MAX_POINTS_DEF,
    parameter int MAX_CONTOURS = gopd_pkg::MAX_CONTOURS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gopd_pkg::t_cmd  i_cmd,
    output gopd_pkg::t_sts  o_sts,
    input  logic [7:0]      i_byte,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output gopd_pkg::t_res  o_res
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PW = $clog2(MAX_POINTS + 1);
    localparam int CW = $clog2(MAX_CONTOURS + 1);

    logic [15:0]         r_scale;
    logic [15:0]         r_bc;
    logic [7:0]          r_latch;
    logic [CW-1:0]       r_ct;
    logic [15:0]         r_bmx, r_bmy;
    logic [PW-1:0]       r_pi, r_pt;
    logic [7:0]          r_rep;
    logic [15:0]         r_rx, r_ry;
    logic [MAX_POINTS-1:0] r_end;
    logic [4:0]          flag_mem [MAX_POINTS];
    logic [15:0]         x_mem [MAX_POINTS];
    logic [4:0]          r_fl;
    logic [15:0]         r_xr;
    logic [15:0]         r_xo, r_yo;
    logic                r_on, r_cl, r_gl;
    logic                r_ov;
    gopd_pkg::t_res      r_res;

    logic [15:0]   word;
    logic [4:0]    f_byte;
    logic [AW-1:0] pi_a;
    logic [15:0]   dx, dy, n_rx, n_ry;
    logic          fl_en;
    logic [31:0]   mx, my;

    assign word   = {r_latch, i_byte};
    assign f_byte = {i_byte[5:4], i_byte[2:0]};
    assign pi_a   = r_pi[AW-1:0];
    assign fl_en  = i_cmd.flag_wr && (r_pi < r_pt);

    // select deltas
    always_comb begin
        case (i_cmd.x_sel)
            gopd_pkg::DS_SHORT: dx = r_fl[gopd_pkg::FL_XSAME] ? {8'd0, i_byte}
                                                              : 16'd0 - {8'd0, i_byte};
            gopd_pkg::DS_WORD:  dx = word;
            default:            dx = 16'd0;
        endcase
        case (i_cmd.y_sel)
            gopd_pkg::DS_SHORT: dy = r_fl[gopd_pkg::FL_YSAME] ? {8'd0, i_byte}
                                                              : 16'd0 - {8'd0, i_byte};
            gopd_pkg::DS_WORD:  dy = word;
            default:            dy = 16'd0;
        endcase
    end
    assign n_rx = r_rx + dx;
    assign n_ry = r_ry + dy;

    assign mx = r_xo * r_scale;
    assign my = r_yo * r_scale;

    // status back to the controller
    always_comb begin
        o_sts.bc_zero    = (r_bc == 16'd0);
        o_sts.bc_one     = (r_bc == 16'd1);
        o_sts.bc_odd     = r_bc[0];
        o_sts.bc_is3     = (r_bc == 16'd3);
        o_sts.bc_is5     = (r_bc == 16'd5);
        o_sts.bc_is9     = (r_bc == 16'd9);
        o_sts.word_neg   = word[15];
        o_sts.word_gt_mc = (word > 16'(MAX_CONTOURS));
        o_sts.word_zero  = (word == 16'd0);
        o_sts.word_ge_mp = (word >= 16'(MAX_POINTS));
        o_sts.ends_last  = (({1'b0, r_bc[15:1]} + 16'd1) >= 16'(r_ct));
        o_sts.pi_done    = (r_pi >= r_pt);
        o_sts.rep_zero   = (r_rep == 8'd0);
        o_sts.byte_rep   = i_byte[3];
        o_sts.fl         = r_fl;
        o_sts.out_free   = !r_ov || i_out_ready;
    end

    // control counters and header fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= gopd_pkg::SCALE_RESET;
            r_bc    <= '0;
            r_latch <= '0;
            r_ct    <= '0;
            r_bmx   <= '0;
            r_bmy   <= '0;
            r_pi    <= '0;
            r_pt    <= '0;
            r_rep   <= '0;
            r_rx    <= '0;
            r_ry    <= '0;
            r_end   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) r_scale <= i_cfg_data;
            if (i_cmd.glyph_init) begin
                r_ct  <= '0;
                r_pt  <= '0;
                r_rep <= '0;
                r_rx  <= '0;
                r_ry  <= '0;
                r_end <= '0;
            end
            if (i_cmd.latch_byte) r_latch <= i_byte;
            if (i_cmd.latch_flag) r_latch <= {3'd0, f_byte};
            if (i_cmd.bc_clr)        r_bc <= '0;
            else if (i_cmd.bc_set1)  r_bc <= 16'd1;
            else if (i_cmd.bc_inc)   r_bc <= r_bc + 16'd1;
            else if (i_cmd.bc_dec)   r_bc <= r_bc - 16'd1;
            else if (i_cmd.bc_load)  r_bc <= word;
            if (i_cmd.set_ct) r_ct  <= CW'(word);
            if (i_cmd.set_bx) r_bmx <= word;
            if (i_cmd.set_by) r_bmy <= word;
            if (i_cmd.set_end) r_end[word[AW-1:0]] <= 1'b1;
            if (i_cmd.set_pt)  r_pt <= PW'(word[AW-1:0]) + PW'(1);
            if (i_cmd.glyph_init || i_cmd.pi_clr) r_pi <= '0;
            else if (i_cmd.pi_inc || i_cmd.x_wr || fl_en) r_pi <= r_pi + PW'(1);
            if (i_cmd.rep_load)     r_rep <= i_byte;
            else if (i_cmd.rep_dec) r_rep <= r_rep - 8'd1;
            if (i_cmd.x_wr)  r_rx <= n_rx;
            if (i_cmd.y_add) r_ry <= n_ry;
            // hold a word until taken
            if (i_cmd.out_pt || i_cmd.out_err) r_ov <= 1'b1;
            else if (i_out_ready)              r_ov <= 1'b0;
        end
    end

    // flag and X memories, registered read at the point index
    always_ff @(posedge i_clk) begin
        if (fl_en) flag_mem[pi_a] <= i_cmd.flag_rep ? r_latch[4:0] : f_byte;
        if (i_cmd.x_wr) x_mem[pi_a] <= n_rx;
        r_fl <= flag_mem[pi_a];
        r_xr <= x_mem[pi_a];
    end

    // offsets, then scaled result into the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.stage) begin
            r_xo <= r_xr - r_bmx;
            r_yo <= r_ry - r_bmy;
            r_on <= r_fl[gopd_pkg::FL_ON];
            r_cl <= r_end[pi_a];
            r_gl <= ((r_pi + PW'(1)) == r_pt);
        end
        if (i_cmd.out_pt) begin
            r_res.x_offset     <= r_xo;
            r_res.y_offset     <= r_yo;
            r_res.x_scaled     <= mx[31:8];
            r_res.y_scaled     <= my[31:8];
            r_res.on_curve     <= r_on;
            r_res.contour_last <= r_cl;
            r_res.glyph_last   <= r_gl;
            r_res.error_code   <= gopd_pkg::ERR_OK;
        end else if (i_cmd.out_err) begin
            r_res <= '{x_offset: 16'd0, y_offset: 16'd0, x_scaled: 24'd0,
                       y_scaled: 24'd0, on_curve: 1'b0, contour_last: 1'b0,
                       glyph_last: 1'b1, error_code: i_cmd.err_code};
        end
    end

    assign o_out_valid = r_ov;
    assign o_res       = r_res;

endmodule

>>> rtl/gopd_ctrl.sv
// Controller of the glyph outline point decoder: record phase and the
// sequencer for flag repeats, X and Y point passes and result loads. Uses gopd_pkg.
module gopd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_glyph_start,
    output logic           o_in_ready,
    input  gopd_pkg::t_sts i_sts,
    output gopd_pkg::t_cmd o_cmd
);
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_ENDS   = 3'd2;
    localparam logic [2:0] PH_INSLEN = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;
    localparam logic [2:0] PH_FLAGS  = 3'd5;
    localparam logic [2:0] PH_XDATA  = 3'd6;
    localparam logic [2:0] PH_YDATA  = 3'd7;

    localparam logic [3:0] S_IN   = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_FCHK = 4'd2;
    localparam logic [3:0] S_REP  = 4'd3;
    localparam logic [3:0] S_XF   = 4'd4;
    localparam logic [3:0] S_XC   = 4'd5;
    localparam logic [3:0] S_YF   = 4'd6;
    localparam logic [3:0] S_YC   = 4'd7;
    localparam logic [3:0] S_E1   = 4'd8;
    localparam logic [3:0] S_E2   = 4'd9;

    logic [3:0] r_state, n_state;
    logic [2:0] r_phase, n_phase;
    logic [1:0] r_err, n_err;

    assign o_in_ready = (r_state == S_IN);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_err   = r_err;
        o_cmd   = '0;
        o_cmd.err_code = r_err;
        unique case (r_state)
            S_IN: begin
                if (i_in_valid && i_glyph_start) begin
                    o_cmd.glyph_init = 1'b1;
                    o_cmd.latch_byte = 1'b1;
                    o_cmd.bc_set1    = 1'b1;
                    n_phase          = PH_HEADER;
                end else if (i_in_valid) begin
                    unique case (r_phase)
                        PH_IDLE: ;
                        PH_HEADER: begin
                            if (!i_sts.bc_odd) begin
                                o_cmd.latch_byte = 1'b1;
                                o_cmd.bc_inc     = 1'b1;
                            end else if (i_sts.bc_one) begin
                                if (i_sts.word_neg) begin
                                    n_err = gopd_pkg::ERR_COMPOSITE;
                                    n_state = S_ERR;
                                    n_phase = PH_IDLE;
                                end else if (i_sts.word_gt_mc) begin
                                    n_err = gopd_pkg::ERR_CONTOURS;
                                    n_state = S_ERR;
                                    n_phase = PH_IDLE;
                                end else if (i_sts.word_zero) begin
                                    n_phase = PH_IDLE;
                                end else begin
                                    o_cmd.set_ct = 1'b1;
                                    o_cmd.bc_inc = 1'b1;
                                end
                            end else begin
                                o_cmd.set_bx = i_sts.bc_is3;
                                o_cmd.set_by = i_sts.bc_is5;
                                if (i_sts.bc_is9) begin
                                    o_cmd.bc_clr = 1'b1;
                                    n_phase      = PH_ENDS;
                                end else begin
                                    o_cmd.bc_inc = 1'b1;
                                end
                            end
                        end
                        PH_ENDS: begin
                            if (!i_sts.bc_odd) begin
                                o_cmd.latch_byte = 1'b1;
                                o_cmd.bc_inc     = 1'b1;
                            end else if (i_sts.word_ge_mp) begin
                                n_err   = gopd_pkg::ERR_POINTS;
                                n_state = S_ERR;
                                n_phase = PH_IDLE;
                            end else begin
                                o_cmd.set_end = 1'b1;
                                if (i_sts.ends_last) begin
                                    o_cmd.set_pt = 1'b1;
                                    o_cmd.bc_clr = 1'b1;
                                    n_phase      = PH_INSLEN;
                                end else begin
                                    o_cmd.bc_inc = 1'b1;
                                end
                            end
                        end
                        PH_INSLEN: begin
                            if (i_sts.bc_zero) begin
                                o_cmd.latch_byte = 1'b1;
                                o_cmd.bc_set1    = 1'b1;
                            end else if (i_sts.word_zero) begin
                                o_cmd.bc_clr = 1'b1;
                                o_cmd.pi_clr = 1'b1;
                                n_phase      = PH_FLAGS;
                            end else begin
                                o_cmd.bc_load = 1'b1;
                                n_phase       = PH_SKIP;
                            end
                        end
                        PH_SKIP: begin
                            o_cmd.bc_dec = 1'b1;
                            if (i_sts.bc_one) begin
                                o_cmd.pi_clr = 1'b1;
                                n_phase      = PH_FLAGS;
                            end
                        end
                        PH_FLAGS: begin
                            if (i_sts.bc_zero) begin
                                o_cmd.flag_wr = 1'b1;
                                if (i_sts.byte_rep) begin
                                    o_cmd.latch_flag = 1'b1;
                                    o_cmd.bc_set1    = 1'b1;
                                end else begin
                                    n_state = S_FCHK;
                                end
                            end else begin
                                o_cmd.rep_load = 1'b1;
                                o_cmd.bc_clr   = 1'b1;
                                n_state        = S_REP;
                            end
                        end
                        PH_XDATA: begin
                            if (i_sts.fl[gopd_pkg::FL_XSHORT]) begin
                                o_cmd.x_wr  = 1'b1;
                                o_cmd.x_sel = gopd_pkg::DS_SHORT;
                                n_state     = S_XF;
                            end else if (i_sts.bc_zero) begin
                                o_cmd.latch_byte = 1'b1;
                                o_cmd.bc_set1    = 1'b1;
                            end else begin
                                o_cmd.bc_clr = 1'b1;
                                o_cmd.x_wr   = 1'b1;
                                o_cmd.x_sel  = gopd_pkg::DS_WORD;
                                n_state      = S_XF;
                            end
                        end
                        PH_YDATA: begin
                            if (i_sts.fl[gopd_pkg::FL_YSHORT]) begin
                                o_cmd.y_add = 1'b1;
                                o_cmd.y_sel = gopd_pkg::DS_SHORT;
                                n_state     = S_E1;
                            end else if (i_sts.bc_zero) begin
                                o_cmd.latch_byte = 1'b1;
                                o_cmd.bc_set1    = 1'b1;
                            end else begin
                                o_cmd.bc_clr = 1'b1;
                                o_cmd.y_add  = 1'b1;
                                o_cmd.y_sel  = gopd_pkg::DS_WORD;
                                n_state      = S_E1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // load the error word once the output slot is free
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_err = 1'b1;
                    n_state       = S_IN;
                end
            end
            // expand a repeat count one flag per cycle
            S_REP: begin
                if (i_sts.rep_zero || i_sts.pi_done) begin
                    n_state = S_FCHK;
                end else begin
                    o_cmd.flag_wr  = 1'b1;
                    o_cmd.flag_rep = 1'b1;
                    o_cmd.rep_dec  = 1'b1;
                end
            end
            S_FCHK: begin
                if (i_sts.pi_done) begin
                    o_cmd.pi_clr = 1'b1;
                    o_cmd.bc_clr = 1'b1;
                    n_phase      = PH_XDATA;
                    n_state      = S_XF;
                end else begin
                    n_state = S_IN;
                end
            end
            S_XF: n_state = S_XC;
            // pass points whose X delta takes no bytes
            S_XC: begin
                if (i_sts.pi_done) begin
                    o_cmd.pi_clr = 1'b1;
                    o_cmd.bc_clr = 1'b1;
                    n_phase      = PH_YDATA;
                    n_state      = S_YF;
                end else if (!i_sts.fl[gopd_pkg::FL_XSHORT] && i_sts.fl[gopd_pkg::FL_XSAME]) begin
                    o_cmd.x_wr  = 1'b1;
                    o_cmd.x_sel = gopd_pkg::DS_ZERO;
                    n_state     = S_XF;
                end else begin
                    n_state = S_IN;
                end
            end
            S_YF: n_state = S_YC;
            // emit points whose Y delta takes no bytes
            S_YC: begin
                if (i_sts.pi_done) begin
                    n_phase = PH_IDLE;
                    n_state = S_IN;
                end else if (!i_sts.fl[gopd_pkg::FL_YSHORT] && i_sts.fl[gopd_pkg::FL_YSAME]) begin
                    n_state = S_E1;
                end else begin
                    n_state = S_IN;
                end
            end
            S_E1: begin
                o_cmd.stage = 1'b1;
                n_state     = S_E2;
            end
            S_E2: begin
                if (i_sts.out_free) begin
                    o_cmd.out_pt = 1'b1;
                    o_cmd.pi_inc = 1'b1;
                    n_state      = S_YF;
                end
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_phase <= PH_IDLE;
            r_err   <= gopd_pkg::ERR_OK;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_err   <= n_err;
        end
    end

endmodule

>>> rtl/gopd_chk.sv
// Port-level checker for the glyph outline point decoder and its bind.
// Depends on the top level's port names and gopd_pkg.
module gopd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_x_offset,
    input logic [15:0] i_y_offset,
    input logic        i_contour_last,
    input logic        i_glyph_last,
    input logic [1:0]  i_error_code
);
    // hold a stalled word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_x_offset)
            && $stable(i_y_offset) && $stable(i_error_code))
        else $error("output word changed while stalled");

    // error words carry no point and end the glyph
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_error_code != gopd_pkg::ERR_OK) |-> i_glyph_last
            && !i_contour_last && (i_x_offset == 16'd0) && (i_y_offset == 16'd0))
        else $error("error word not clean");

    // the last point of a glyph always closes a contour
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_glyph_last && (i_error_code == gopd_pkg::ERR_OK) |-> i_contour_last)
        else $error("glyph ended inside a contour");

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind glyph_outline_point_decoder gopd_chk u_gopd_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_x_offset     (o_out.x_offset),
    .i_y_offset     (o_out.y_offset),
    .i_contour_last (o_out.contour_last),
    .i_glyph_last   (o_out.glyph_last),
    .i_error_code   (o_out.error_code)
);

>>> test/tb.sv
// Testbench of glyph_outline_point_decoder: random and directed glyph records
// are sent byte by byte, and each point word is checked against a local predictor.
// Depends on gopd_pkg, gopd_ifs and the RTL of the decoder.
module tb;

    localparam int N_PTS  = gopd_pkg::MAX_POINTS_DEF;
    localparam int N_CONT = gopd_pkg::MAX_CONTOURS_DEF;
    localparam int DRAIN_CYCLES = 1500;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef enum int {ST_IDLE, ST_HEADER, ST_ENDS, ST_INSLEN, ST_SKIP,
                      ST_FLAGS, ST_XDATA, ST_YDATA} t_step;

    typedef struct {
        logic [7:0] b;
        logic       s;
    } t_word;

    // Predictor of the decoder and store of expected point words
    class glyph_scoreboard;
        logic [15:0] scale;
        t_step       st;
        logic [15:0] bcnt;
        logic [7:0]  latch;
        int          ctot;
        logic [15:0] bmin_x, bmin_y;
        logic [5:0]  ends [N_CONT];
        logic [4:0]  flags [N_PTS];
        logic [15:0] xs [N_PTS];
        int          pidx, ptot;
        logic [15:0] run_x, run_y;
        gopd_pkg::t_res expected_points [$];
        int          errors;

        function new();
            scale = gopd_pkg::SCALE_RESET;
            st = ST_IDLE;
            bcnt = '0; latch = '0; ctot = 0; bmin_x = '0; bmin_y = '0;
            pidx = 0; ptot = 0; run_x = '0; run_y = '0; errors = 0;
        endfunction

        function void push_error(logic [1:0] code);
            gopd_pkg::t_res r;
            r = '0;
            r.glyph_last = 1'b1;
            r.error_code = code;
            expected_points.push_back(r);
            st = ST_IDLE;
        endfunction

        function void push_point(int idx);
            gopd_pkg::t_res r;
            logic [31:0] px, py;
            r = '0;
            r.x_offset = xs[idx % N_PTS] - bmin_x;
            r.y_offset = run_y - bmin_y;
            px = 32'(r.x_offset) * 32'(scale);
            py = 32'(r.y_offset) * 32'(scale);
            r.x_scaled = px[31:8];
            r.y_scaled = py[31:8];
            r.on_curve = flags[idx % N_PTS][gopd_pkg::FL_ON];
            for (int c = 0; c < ctot && c < N_CONT; c++)
                if (32'(ends[c]) == idx) r.contour_last = 1'b1;
            r.glyph_last = (idx + 1 == ptot);
            r.error_code = gopd_pkg::ERR_OK;
            expected_points.push_back(r);
        endfunction

        // emit points with no Y bytes, finish the glyph at the end
        function void run_y_zero();
            logic [4:0] f;
            while (pidx < ptot) begin
                f = flags[pidx % N_PTS];
                if (f[gopd_pkg::FL_YSHORT] || !f[gopd_pkg::FL_YSAME]) return;
                push_point(pidx);
                pidx++;
            end
            st = ST_IDLE;
        endfunction

        function void put_x(logic [15:0] d);
            run_x = run_x + d;
            xs[pidx % N_PTS] = run_x;
            pidx++;
        endfunction

        // pass points with no X bytes, enter the Y part at the end
        function void run_x_zero();
            logic [4:0] f;
            while (pidx < ptot) begin
                f = flags[pidx % N_PTS];
                if (f[gopd_pkg::FL_XSHORT] || !f[gopd_pkg::FL_XSAME]) return;
                put_x(16'd0);
            end
            st = ST_YDATA;
            pidx = 0;
            bcnt = '0;
            run_y_zero();
        endfunction

        function void put_flag(logic [4:0] f);
            if (pidx < ptot) begin
                flags[pidx % N_PTS] = f;
                pidx++;
            end
        endfunction

        function void note_byte(logic [7:0] b, logic s);
            logic [15:0] w;
            logic [4:0]  f;
            logic [15:0] d;
            w = {latch, b};
            if (s) begin
                st = ST_HEADER; bcnt = '0; ctot = 0; pidx = 0; ptot = 0;
                run_x = '0; run_y = '0;
            end
            case (st)
                ST_HEADER: begin
                    if (!bcnt[0]) begin
                        latch = b;
                    end else if (bcnt == 1) begin
                        if (w[15]) begin
                            push_error(gopd_pkg::ERR_COMPOSITE);
                            return;
                        end
                        if (w > N_CONT) begin
                            push_error(gopd_pkg::ERR_CONTOURS);
                            return;
                        end
                        if (w == 0) begin
                            st = ST_IDLE;
                            return;
                        end
                        ctot = w;
                    end else if (bcnt == 3) begin
                        bmin_x = w;
                    end else if (bcnt == 5) begin
                        bmin_y = w;
                    end
                    bcnt++;
                    if (bcnt >= 10) begin
                        st = ST_ENDS;
                        bcnt = '0;
                    end
                end
                ST_ENDS: begin
                    if (!bcnt[0]) begin
                        latch = b;
                        bcnt++;
                    end else if (w >= N_PTS) begin
                        push_error(gopd_pkg::ERR_POINTS);
                    end else begin
                        ends[(bcnt >> 1) % N_CONT] = w[5:0];
                        if ((bcnt >> 1) + 1 >= ctot) begin
                            ptot = w + 1;
                            st = ST_INSLEN;
                            bcnt = '0;
                        end else begin
                            bcnt++;
                        end
                    end
                end
                ST_INSLEN: begin
                    if (bcnt == 0) begin
                        latch = b;
                        bcnt = 1;
                    end else if (w == 0) begin
                        st = ST_FLAGS; bcnt = '0; pidx = 0;
                    end else begin
                        st = ST_SKIP; bcnt = w;
                    end
                end
                ST_SKIP: begin
                    bcnt = bcnt - 1;
                    if (bcnt == 0) begin
                        st = ST_FLAGS;
                        pidx = 0;
                    end
                end
                ST_FLAGS: begin
                    if (bcnt == 0) begin
                        f = {b[5:4], b[2:0]};
                        put_flag(f);
                        if (b[3]) begin
                            latch = {3'b0, f};
                            bcnt = 1;
                            return;
                        end
                    end else begin
                        for (int k = 0; k < b; k++) put_flag(latch[4:0]);
                        bcnt = '0;
                    end
                    if (pidx >= ptot) begin
                        st = ST_XDATA; pidx = 0; bcnt = '0;
                        run_x_zero();
                    end
                end
                ST_XDATA: begin
                    f = flags[pidx % N_PTS];
                    if (f[gopd_pkg::FL_XSHORT]) begin
                        put_x(f[gopd_pkg::FL_XSAME] ? {8'd0, b} : 16'd0 - {8'd0, b});
                    end else if (bcnt == 0) begin
                        latch = b;
                        bcnt = 1;
                        return;
                    end else begin
                        bcnt = '0;
                        put_x(w);
                    end
                    run_x_zero();
                end
                ST_YDATA: begin
                    f = flags[pidx % N_PTS];
                    if (f[gopd_pkg::FL_YSHORT]) begin
                        d = f[gopd_pkg::FL_YSAME] ? {8'd0, b} : 16'd0 - {8'd0, b};
                    end else if (bcnt == 0) begin
                        latch = b;
                        bcnt = 1;
                        return;
                    end else begin
                        bcnt = '0;
                        d = w;
                    end
                    run_y = run_y + d;
                    push_point(pidx);
                    pidx++;
                    run_y_zero();
                end
                default: ;
            endcase
        endfunction

        function void check_point(gopd_pkg::t_res got);
            gopd_pkg::t_res e;
            if (expected_points.size() == 0) begin
                $error("point word with none expected: %p", got);
                errors++;
                return;
            end
            e = expected_points.pop_front();
            if (got.x_offset !== e.x_offset) begin
                $error("x_offset exp %0h got %0h", e.x_offset, got.x_offset); errors++;
            end
            if (got.y_offset !== e.y_offset) begin
                $error("y_offset exp %0h got %0h", e.y_offset, got.y_offset); errors++;
            end
            if (got.x_scaled !== e.x_scaled) begin
                $error("x_scaled exp %0h got %0h", e.x_scaled, got.x_scaled); errors++;
            end
            if (got.y_scaled !== e.y_scaled) begin
                $error("y_scaled exp %0h got %0h", e.y_scaled, got.y_scaled); errors++;
            end
            if (got.on_curve !== e.on_curve) begin
                $error("on_curve exp %0b got %0b", e.on_curve, got.on_curve); errors++;
            end
            if (got.contour_last !== e.contour_last) begin
                $error("contour_last exp %0b got %0b", e.contour_last, got.contour_last);
                errors++;
            end
            if (got.glyph_last !== e.glyph_last) begin
                $error("glyph_last exp %0b got %0b", e.glyph_last, got.glyph_last); errors++;
            end
            if (got.error_code !== e.error_code) begin
                $error("error_code exp %0d got %0d", e.error_code, got.error_code); errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    longint cycles = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int sent = 0;
    t_word record_q [$];
    glyph_scoreboard sb;

    gopd_in_if  in_ch ();
    gopd_out_if out_ch ();
    gopd_cfg_if cfg_ch ();

    glyph_outline_point_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.glyph_start = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        sb = new();
    end

    // check accepted point words, then draw the next ready
    always @(posedge i_clk) begin
        gopd_pkg::t_res got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.x_offset = out_ch.x_offset;
            got.y_offset = out_ch.y_offset;
            got.x_scaled = out_ch.x_scaled;
            got.y_scaled = out_ch.y_scaled;
            got.on_curve = out_ch.on_curve;
            got.contour_last = out_ch.contour_last;
            got.glyph_last = out_ch.glyph_last;
            got.error_code = out_ch.error_code;
            sb.check_point(got);
        end
        out_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall);
    end

    // stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL glyph_outline_point_decoder");
            $finish;
        end
    end

    task automatic send_word(logic [7:0] b, logic s);
        while ($urandom_range(0, 99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.glyph_start <= s;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_byte(b, s);
        sent++;
    endtask

    task automatic flush_record();
        t_word w;
        while (record_q.size() != 0) begin
            w = record_q.pop_front();
            send_word(w.b, w.s);
        end
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (sb.expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scale(logic [15:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.scale = v;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void put(logic [7:0] b, logic s = 1'b0);
        t_word w;
        w.b = b;
        w.s = s;
        record_q.push_back(w);
    endfunction

    function automatic void put16(logic [15:0] v);
        put(v[15:8]);
        put(v[7:0]);
    endfunction

    function automatic logic [15:0] box_value();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Build one record: ncont contours over npts points. An end past the
    // point limit stops the record after the ends; cut keeps that many bytes.
    function automatic void add_glyph(int ncont, int npts, int inslen,
                                      bit unsorted = 0, int cut = 0);
        int ends_list [$];
        logic [4:0] fl [$];
        logic [7:0] b;
        int r, first;
        first = record_q.size();
        put(8'(ncont >> 8), 1'b1);
        put(8'(ncont));
        repeat (4) put16(box_value());
        for (int k = 0; k < ncont - 1; k++) ends_list.push_back($urandom_range(0, npts - 1));
        if (!unsorted) ends_list.sort();
        ends_list.push_back(npts - 1);
        foreach (ends_list[k]) put16(16'(ends_list[k]));
        if (npts <= N_PTS) begin
            put16(16'(inslen));
            repeat (inslen) put(8'($urandom));
            while (fl.size() < npts) begin
                b = 8'($urandom);
                if ($urandom_range(0, 2) == 0) b[5:4] = 2'b11;
                put(b);
                fl.push_back({b[5:4], b[2:0]});
                if (b[3]) begin
                    r = $urandom_range(0, npts - fl.size() + ($urandom_range(0, 7) == 0 ? 5 : 0));
                    put(8'(r));
                    for (int k = 0; k < r && fl.size() < npts; k++) fl.push_back({b[5:4], b[2:0]});
                end
            end
            foreach (fl[k]) begin
                if (fl[k][gopd_pkg::FL_XSHORT]) put(8'($urandom));
                else if (!fl[k][gopd_pkg::FL_XSAME]) put16(16'($urandom));
            end
            foreach (fl[k]) begin
                if (fl[k][gopd_pkg::FL_YSHORT]) put(8'($urandom));
                else if (!fl[k][gopd_pkg::FL_YSAME]) put16(16'($urandom));
            end
        end
        if (cut > 0)
            while (record_q.size() > first + cut) void'(record_q.pop_back());
    endfunction

    task automatic random_glyphs(int count);
        int sel, np;
        for (int g = 0; g < count; g++) begin
            sel = $urandom_range(0, 99);
            np = ($urandom_range(0, 30) == 0) ? N_PTS : $urandom_range(1, 12);
            if (sel < 70) begin
                add_glyph($urandom_range(1, (np < 4) ? np : 4), np, $urandom_range(0, 3));
            end else if (sel < 78) begin
                add_glyph($urandom_range(1, 3), np, $urandom_range(0, 2), 1);
            end else if (sel < 86) begin
                add_glyph($urandom_range(1, 3), np, 1, 0, $urandom_range(1, 25));
            end else if (sel < 90) begin
                add_glyph(1, $urandom_range(N_PTS + 1, 300), 0);
            end else if (sel < 93) begin
                put16(16'($urandom_range(16'h8000, 16'hFFFF)));
                record_q[record_q.size() - 2].s = 1'b1;
            end else if (sel < 96) begin
                put16(16'($urandom_range(N_CONT + 1, 16'h7FFF)));
                record_q[record_q.size() - 2].s = 1'b1;
            end else begin
                repeat ($urandom_range(1, 4)) put(8'($urandom));
            end
            flush_record();
            if (g == count / 2 && count > 4) wait_idle();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed records at the default scale
        put(8'hA5); put(8'h5A);                  // bytes while idle
        put16(16'd0); record_q[record_q.size() - 2].s = 1'b1;   // empty glyph
        put16(16'hFFFF); record_q[record_q.size() - 2].s = 1'b1; // composite
        put16(16'd17); record_q[record_q.size() - 2].s = 1'b1;   // too many contours
        flush_record();
        add_glyph(1, N_PTS + 1, 0);              // end past the point limit
        add_glyph(2, 5, 2, 0, 9);                // abandoned mid-record
        add_glyph(1, 1, 0);
        add_glyph(N_CONT, N_CONT, 0, 1);
        add_glyph(3, 8, 0, 1);
        flush_record();
        put(8'h00, 1'b1); put(8'h01);            // one point, no coordinate bytes
        repeat (4) put16(16'hFFFF);
        put16(16'd0); put16(16'd0);
        put(8'h31);
        put(8'h77);                               // ignored after the glyph ends
        flush_record();
        wait_idle();

        // phases of idling, each under its own scale
        write_scale(16'd1);
        send_idle = 0; recv_stall = 0;
        do random_glyphs(1); while (sent < 240);
        wait_idle();
        write_scale(16'hFFFF);
        send_idle = 51; recv_stall = 0;
        do random_glyphs(1); while (sent < 290);
        wait_idle();
        write_scale(16'($urandom_range(1, 16'hFFFF)));
        send_idle = 0; recv_stall = 51;
        do random_glyphs(1); while (sent < 340);
        wait_idle();
        write_scale(gopd_pkg::SCALE_RESET);
        send_idle = 9; recv_stall = 9;
        do random_glyphs(1); while (sent < 400);
        in_ch.valid <= 1'b0;

        while (sb.expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_points.size() == 0) begin
            $display("PASS glyph_outline_point_decoder");
        end else begin
            $display("FAIL glyph_outline_point_decoder");
        end
        $finish;
    end
endmodule
